FILE: hw/rtl/touch_contact_tracker_top_defines.svh
// ----------------------------------------------------------------------------
// Touch contact tracker: assertion macros
// Shared macros for the concurrent checks on the tracker ports.
// ----------------------------------------------------------------------------
`ifndef TOUCH_CONTACT_TRACKER_TOP_DEFINES_SVH
`define TOUCH_CONTACT_TRACKER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TCT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tracker check failed");

// Check a property on every clock edge, reset included.
`define TCT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tracker reset check failed");

`endif

FILE: hw/rtl/tct_pkg.sv
// ----------------------------------------------------------------------------
// Touch contact tracker package
// Shared types, opcodes and the contact update function.
// ----------------------------------------------------------------------------
`default_nettype none

package tct_pkg;

  localparam int DEF_MAX_CONTACTS = 8;
  localparam logic [31:0] MOUSE_ID = 32'd1;

  // Flag bit positions
  localparam int FL_ACTIVE  = 0;
  localparam int FL_PRESSED = 1;
  localparam int FL_STARTED = 2;
  localparam int FL_ENDED   = 3;

  typedef enum logic [3:0] {
    OP_TOUCH_START = 4'd0,
    OP_TOUCH_MOVE  = 4'd1,
    OP_TOUCH_END   = 4'd2,
    OP_MOUSE_DOWN  = 4'd3,
    OP_MOUSE_UP    = 4'd4,
    OP_MOUSE_MOVE  = 4'd5,
    OP_MOUSE_ENTER = 4'd6,
    OP_MOUSE_EXIT  = 4'd7,
    OP_FRAME_END   = 4'd8
  } op_t;

  typedef struct packed {
    logic [31:0]        id;
    logic [3:0]         flags;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
  } entry_t;

  typedef struct packed {
    logic [2:0] slot;
    logic       table_full;
    entry_t     entry;
    logic [3:0] live_count;
  } result_t;

  // Apply one touch or mouse event to a contact entry.
  function automatic entry_t apply_update(entry_t e, logic [3:0] op,
                                          logic signed [15:0] x,
                                          logic signed [15:0] y);
    entry_t r;
    logic   prev;
    logic   act;
    r    = e;
    prev = e.flags[FL_ACTIVE];
    if (op == OP_TOUCH_START || op == OP_TOUCH_MOVE || op == OP_TOUCH_END) begin
      act = (op != OP_TOUCH_END);
    end else if (!prev && op == OP_MOUSE_DOWN) begin
      act = 1'b1;
    end else if (prev && (op inside {OP_MOUSE_UP, OP_MOUSE_EXIT})) begin
      act = 1'b0;
    end else begin
      act = prev;
    end
    r.flags              = '0;
    r.flags[FL_ACTIVE]   = act;
    r.flags[FL_PRESSED]  = act;
    r.flags[FL_STARTED]  = act && !prev;
    r.flags[FL_ENDED]    = !act && prev;
    r.cur_x = x;
    r.cur_y = y;
    if (act && !prev) begin
      r.start_x = x;
      r.start_y = y;
    end
    if (!act && prev) begin
      r.end_x = x;
      r.end_y = y;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tct_if.sv
// ----------------------------------------------------------------------------
// Touch contact tracker channels
// Event input, contact report output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tct_event_if;
  logic               valid;
  logic               ready;
  logic [3:0]         opcode;
  logic [31:0]        contact_id;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;

  modport source (output valid, opcode, contact_id, pos_x, pos_y, input ready);
  modport sink   (input valid, opcode, contact_id, pos_x, pos_y, output ready);
endinterface

interface tct_report_if;
  logic               valid;
  logic               ready;
  logic [2:0]         slot;
  logic               table_full;
  logic [3:0]         flags;
  logic [31:0]        id_out;
  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic [3:0]         live_count;

  modport source (output valid, slot, table_full, flags, id_out, cur_x, cur_y,
                  start_x, start_y, end_x, end_y, live_count, input ready);
  modport sink   (input valid, slot, table_full, flags, id_out, cur_x, cur_y,
                  start_x, start_y, end_x, end_y, live_count, output ready);
endinterface

interface tct_cfg_if;
  logic valid;
  logic ready;
  logic mouse_as_touch;

  modport source (output valid, mouse_as_touch, input ready);
  modport sink   (input valid, mouse_as_touch, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tct_table.sv
// ----------------------------------------------------------------------------
// Touch contact tracker table
// Single write, single registered read contact entry memory.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_table #(
  parameter int MAX_CONTACTS = tct_pkg::DEF_MAX_CONTACTS,
  parameter int IW           = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [IW-1:0]        waddr,
  input  wire tct_pkg::entry_t      wdata,
  input  wire logic [IW-1:0]        raddr,
  output tct_pkg::entry_t           rdata
);

  tct_pkg::entry_t mem [MAX_CONTACTS];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tct_seq.sv
// ----------------------------------------------------------------------------
// Touch contact tracker sequencer
// Walks the table one entry per step with a shared id compare and index
// counter: lookup/insert, contact update and frame-end compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_seq #(
  parameter int MAX_CONTACTS = tct_pkg::DEF_MAX_CONTACTS,
  parameter int IW           = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1,
  parameter int CW           = $clog2(MAX_CONTACTS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // event side
  input  wire logic               evt_valid,
  output logic                    evt_ready,
  input  wire logic [3:0]         evt_op,
  input  wire logic [31:0]        evt_id,
  input  wire logic signed [15:0] evt_x,
  input  wire logic signed [15:0] evt_y,
  input  wire logic               mouse_as_touch,
  // result side
  input  wire logic               res_free,
  output logic                    res_load,
  output tct_pkg::result_t        res_data,
  // table side
  output logic                    mem_we,
  output logic [IW-1:0]           mem_waddr,
  output tct_pkg::entry_t         mem_wdata,
  output logic [IW-1:0]           mem_raddr,
  input  wire tct_pkg::entry_t    mem_rdata
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN    = 7'b0000010,
    S_UPDATE  = 7'b0000100,
    S_EMIT    = 7'b0001000,
    S_C_READ  = 7'b0010000,
    S_C_CHECK = 7'b0100000,
    S_C_MOVE  = 7'b1000000
  } state_t;

  state_t                 state, state_next;
  logic [CW-1:0]          count, count_next;
  logic [CW-1:0]          idx, idx_next;
  logic                   cmp_valid, cmp_valid_next;
  logic [IW-1:0]          cmp_idx, cmp_idx_next;
  logic [IW-1:0]          slot_reg, slot_reg_next;
  logic                   full_reg, full_reg_next;
  tct_pkg::entry_t        entry_reg, entry_reg_next;
  logic [3:0]             op_reg, op_reg_next;
  logic [31:0]            id_reg, id_reg_next;
  logic signed [15:0]     x_reg, x_reg_next;
  logic signed [15:0]     y_reg, y_reg_next;

  logic                   is_touch;
  logic                   is_mouse;
  logic                   id_hit;
  logic [CW-1:0]          count_m1;
  tct_pkg::entry_t        updated;

  assign is_touch = (evt_op == tct_pkg::OP_TOUCH_START) ||
                    (evt_op == tct_pkg::OP_TOUCH_MOVE)  ||
                    (evt_op == tct_pkg::OP_TOUCH_END);
  assign is_mouse = (evt_op == tct_pkg::OP_MOUSE_DOWN)  ||
                    (evt_op == tct_pkg::OP_MOUSE_UP)    ||
                    (evt_op == tct_pkg::OP_MOUSE_MOVE)  ||
                    (evt_op == tct_pkg::OP_MOUSE_ENTER) ||
                    (evt_op == tct_pkg::OP_MOUSE_EXIT);

  // Shared compare unit: id match on the entry read last cycle
  assign id_hit   = cmp_valid && (mem_rdata.id == id_reg);
  assign count_m1 = count - CW'(1);
  assign updated  = tct_pkg::apply_update(entry_reg, op_reg, x_reg, y_reg);

  assign evt_ready = (state == S_IDLE);

  // Result payload
  always_comb begin
    res_data            = '0;
    res_data.slot       = 3'(slot_reg);
    res_data.table_full = full_reg;
    res_data.entry      = entry_reg;
    res_data.live_count = 4'(count);
  end

  // Sequencer
  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    cmp_valid_next = cmp_valid;
    cmp_idx_next   = cmp_idx;
    slot_reg_next  = slot_reg;
    full_reg_next  = full_reg;
    entry_reg_next = entry_reg;
    op_reg_next    = op_reg;
    id_reg_next    = id_reg;
    x_reg_next     = x_reg;
    y_reg_next     = y_reg;
    mem_we         = 1'b0;
    mem_waddr      = slot_reg;
    mem_wdata      = updated;
    mem_raddr      = idx[IW-1:0];
    res_load       = 1'b0;

    case (state)
      S_IDLE: begin
        if (evt_valid) begin
          op_reg_next    = evt_op;
          id_reg_next    = is_mouse ? tct_pkg::MOUSE_ID : evt_id;
          x_reg_next     = evt_x;
          y_reg_next     = evt_y;
          idx_next       = '0;
          cmp_valid_next = 1'b0;
          if (evt_op == tct_pkg::OP_FRAME_END) begin
            state_next = S_C_READ;
          end else if (is_touch || (is_mouse && mouse_as_touch)) begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (id_hit) begin
          // Found: take the entry and update it
          cmp_valid_next = 1'b0;
          slot_reg_next  = cmp_idx;
          full_reg_next  = 1'b0;
          entry_reg_next = mem_rdata;
          state_next     = S_UPDATE;
        end else if (idx < count) begin
          // Advance: read the next entry, compare next cycle
          mem_raddr      = idx[IW-1:0];
          cmp_valid_next = 1'b1;
          cmp_idx_next   = idx[IW-1:0];
          idx_next       = idx + CW'(1);
        end else if (count < CW'(MAX_CONTACTS)) begin
          // Insert at the end with cleared fields
          cmp_valid_next    = 1'b0;
          slot_reg_next     = count[IW-1:0];
          full_reg_next     = 1'b0;
          entry_reg_next    = '0;
          entry_reg_next.id = id_reg;
          count_next        = count + CW'(1);
          state_next        = S_UPDATE;
        end else begin
          // Drop: table full
          cmp_valid_next    = 1'b0;
          slot_reg_next     = '0;
          full_reg_next     = 1'b1;
          entry_reg_next    = '0;
          entry_reg_next.id = id_reg;
          state_next        = S_EMIT;
        end
      end

      S_UPDATE: begin
        mem_we         = 1'b1;
        mem_waddr      = slot_reg;
        mem_wdata      = updated;
        entry_reg_next = updated;
        state_next     = S_EMIT;
      end

      S_EMIT: begin
        if (res_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_C_READ: begin
        mem_raddr = idx[IW-1:0];
        if (idx < count) begin
          state_next = S_C_CHECK;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_C_CHECK: begin
        if (mem_rdata.flags[tct_pkg::FL_ACTIVE]) begin
          idx_next   = idx + CW'(1);
          state_next = S_C_READ;
        end else begin
          // Remove: pull the last entry into the hole
          count_next = count_m1;
          mem_raddr  = count_m1[IW-1:0];
          if (count_m1 != idx) begin
            state_next = S_C_MOVE;
          end else begin
            state_next = S_C_READ;
          end
        end
      end

      S_C_MOVE: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[IW-1:0];
        mem_wdata  = mem_rdata;
        state_next = S_C_READ;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      idx       <= idx_next;
      cmp_valid <= cmp_valid_next;
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    cmp_idx   <= cmp_idx_next;
    slot_reg  <= slot_reg_next;
    full_reg  <= full_reg_next;
    entry_reg <= entry_reg_next;
    op_reg    <= op_reg_next;
    id_reg    <= id_reg_next;
    x_reg     <= x_reg_next;
    y_reg     <= y_reg_next;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/touch_contact_tracker_top.sv
// ----------------------------------------------------------------------------
// Touch contact tracker
// Keeps up to MAX_CONTACTS touch contacts, updates them per event and
// compacts inactive ones at frame end.
// ----------------------------------------------------------------------------
//  channel  | dir | transaction
//  ---------+-----+---------------------------------------------------------
//  touch    | in  | one event: opcode, contact_id, pos_x, pos_y
//  report   | out | one contact report (slot, flags, positions, live_count)
//  cfg      | in  | write of mouse_as_touch, always ready
//
//  A touch or mouse event walks the single-read-port table one entry per
//  cycle in its lookup, over at most the N live entries (MAX_CONTACTS when
//  full). Frame end checks each live entry and pulls the last entry into
//  each removed one unless it is the last. Ignored events make no report.
//  The report register frees the sequencer, which waits only if a previous
//  report is still stalled. Reset clears the entry count; entries past the
//  count are never read, so the table needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_contact_tracker_top #(
  parameter int MAX_CONTACTS = tct_pkg::DEF_MAX_CONTACTS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  tct_event_if.sink     touch,
  tct_report_if.source  report,
  tct_cfg_if.sink       cfg
);

  localparam int IW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
  localparam int CW = $clog2(MAX_CONTACTS + 1);

  logic              mouse_as_touch;
  logic              res_valid;
  tct_pkg::result_t  res_reg;
  logic              res_free;
  logic              res_load;
  tct_pkg::result_t  res_data;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  tct_pkg::entry_t   mem_wdata;
  logic [IW-1:0]     mem_raddr;
  tct_pkg::entry_t   mem_rdata;

  // Configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mouse_as_touch <= 1'b0;
    end else if (cfg.valid) begin
      mouse_as_touch <= cfg.mouse_as_touch;
    end
  end

  // Report output register
  assign res_free = !res_valid || report.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (report.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_reg <= res_data;
    end
  end

  assign report.valid      = res_valid;
  assign report.slot       = res_reg.slot;
  assign report.table_full = res_reg.table_full;
  assign report.flags      = res_reg.entry.flags;
  assign report.id_out     = res_reg.entry.id;
  assign report.cur_x      = res_reg.entry.cur_x;
  assign report.cur_y      = res_reg.entry.cur_y;
  assign report.start_x    = res_reg.entry.start_x;
  assign report.start_y    = res_reg.entry.start_y;
  assign report.end_x      = res_reg.entry.end_x;
  assign report.end_y      = res_reg.entry.end_y;
  assign report.live_count = res_reg.live_count;

  tct_seq #(
    .MAX_CONTACTS (MAX_CONTACTS),
    .IW           (IW),
    .CW           (CW)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .evt_valid      (touch.valid),
    .evt_ready      (touch.ready),
    .evt_op         (touch.opcode),
    .evt_id         (touch.contact_id),
    .evt_x          (touch.pos_x),
    .evt_y          (touch.pos_y),
    .mouse_as_touch (mouse_as_touch),
    .res_free       (res_free),
    .res_load       (res_load),
    .res_data       (res_data),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  tct_table #(
    .MAX_CONTACTS (MAX_CONTACTS),
    .IW           (IW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/tct_checker.sv
// ----------------------------------------------------------------------------
// Touch contact tracker port checker
// Concurrent checks on the report channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "touch_contact_tracker_top_defines.svh"

module tct_port_checker #(
  parameter int MAX_CONTACTS = tct_pkg::DEF_MAX_CONTACTS
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  slot,
  input wire logic        table_full,
  input wire logic [3:0]  flags,
  input wire logic [31:0] id_out,
  input wire logic [15:0] cur_x,
  input wire logic [15:0] start_x,
  input wire logic [15:0] end_y,
  input wire logic [3:0]  live_count
);

  // A stalled report holds its payload
  `TCT_ASSERT(a_report_hold, out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(flags) && $stable(id_out) && $stable(cur_x) && $stable(live_count))

  // A dropped event reports a full table and an empty contact
  `TCT_ASSERT(a_full_report, out_valid && table_full |-> slot == 3'd0 && flags == 4'd0 && start_x == 16'd0 && end_y == 16'd0 && live_count == 4'(MAX_CONTACTS))

  // Pressed follows active; started only while active, ended only while not
  `TCT_ASSERT(a_flag_rules, out_valid && !table_full |-> (flags[1] == flags[0]) && !(flags[2] && !flags[0]) && !(flags[3] && flags[0]))

  // No report right after reset
  `TCT_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid)

endmodule

bind touch_contact_tracker_top tct_port_checker #(
  .MAX_CONTACTS (MAX_CONTACTS)
) u_tct_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (report.valid),
  .out_ready  (report.ready),
  .slot       (report.slot),
  .table_full (report.table_full),
  .flags      (report.flags),
  .id_out     (report.id_out),
  .cur_x      (report.cur_x),
  .start_x    (report.start_x),
  .end_y      (report.end_y),
  .live_count (report.live_count)
);

`default_nettype wire

FILE: bench/tct_checker.sv
// ----------------------------------------------------------------------------
// Touch contact tracker checker
// Watches the event, report and configuration channels, keeps its own copy
// of the contact table, predicts one report per tracked touch or mouse event,
// compares every accepted report with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tct_checker (
  input  logic  clk,
  input  logic  rst,
  tct_event_if  touch,
  tct_report_if report,
  tct_cfg_if    cfg,
  output int    fail_count,
  output int    outstanding
);
  import tct_pkg::*;

  localparam int CONTACTS = DEF_MAX_CONTACTS;

  entry_t  contact_tab [CONTACTS];
  int      live_cnt;
  logic    mouse_mode;
  result_t report_q [$];
  int      err_cnt;

  // Drop entries that are no longer active: pull the last entry into the hole
  function automatic void compact_table();
    int i;
    i = 0;
    if (live_cnt > CONTACTS) live_cnt = CONTACTS;
    while (i < live_cnt) begin
      if (contact_tab[i].flags[FL_ACTIVE]) begin
        i++;
      end else begin
        live_cnt--;
        if (live_cnt != i) contact_tab[i] = contact_tab[live_cnt];
        contact_tab[live_cnt] = '0;
      end
    end
  endfunction

  // Update the contact table for one event and queue the report it causes
  function automatic void track_event(logic [3:0] op, logic [31:0] id,
                                      logic signed [15:0] x, logic signed [15:0] y);
    int      slot_idx;
    int      i;
    logic    prev;
    logic    act;
    entry_t  e;
    result_t r;
    if (op == OP_FRAME_END) begin
      compact_table();
      return;
    end
    if (op > OP_FRAME_END) return;
    if (op >= OP_MOUSE_DOWN) begin
      if (!mouse_mode) return;
      id = MOUSE_ID;
    end

    // Look up the contact, insert it at the end of the table if absent and not full
    slot_idx = CONTACTS;
    for (i = 0; i < live_cnt; i++) begin
      if (slot_idx == CONTACTS && contact_tab[i].id == id) slot_idx = i;
    end
    if (slot_idx == CONTACTS && live_cnt < CONTACTS) begin
      slot_idx = live_cnt;
      contact_tab[slot_idx] = '0;
      contact_tab[slot_idx].id = id;
      live_cnt++;
    end

    r = '0;
    r.live_count = live_cnt[3:0];
    if (slot_idx == CONTACTS) begin
      r.table_full = 1'b1;
      r.entry.id   = id;
      report_q.push_back(r);
      return;
    end

    e    = contact_tab[slot_idx];
    prev = e.flags[FL_ACTIVE];
    case (op)
      OP_TOUCH_START, OP_TOUCH_MOVE, OP_MOUSE_DOWN: act = 1'b1;
      OP_TOUCH_END, OP_MOUSE_UP, OP_MOUSE_EXIT:     act = 1'b0;
      default:                                      act = prev;
    endcase

    e.flags              = '0;
    e.flags[FL_ACTIVE]   = act;
    e.flags[FL_PRESSED]  = act;
    e.flags[FL_STARTED]  = act && !prev;
    e.flags[FL_ENDED]    = !act && prev;
    e.cur_x = x;
    e.cur_y = y;
    if (act && !prev) begin
      e.start_x = x;
      e.start_y = y;
    end
    if (!act && prev) begin
      e.end_x = x;
      e.end_y = y;
    end
    contact_tab[slot_idx] = e;

    r.slot  = slot_idx[2:0];
    r.entry = e;
    report_q.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      if (err_cnt < 10)
        $display("%0t: report field %s mismatch: expected %0h, got %0h",
                 $time, name, exp_v, got_v);
      err_cnt++;
    end
  endfunction

  // Compare one accepted report with the oldest prediction
  function automatic void check_report();
    result_t exp_r;
    if (report_q.size() == 0) begin
      if (err_cnt < 10)
        $display("%0t: report for contact %0h arrived with no event pending",
                 $time, report.id_out);
      err_cnt++;
      return;
    end
    exp_r = report_q.pop_front();
    check_field("slot",       exp_r.slot,          report.slot);
    check_field("table_full", exp_r.table_full,    report.table_full);
    check_field("flags",      exp_r.entry.flags,   report.flags);
    check_field("id_out",     exp_r.entry.id,      report.id_out);
    check_field("cur_x",      exp_r.entry.cur_x,   report.cur_x);
    check_field("cur_y",      exp_r.entry.cur_y,   report.cur_y);
    check_field("start_x",    exp_r.entry.start_x, report.start_x);
    check_field("start_y",    exp_r.entry.start_y, report.start_y);
    check_field("end_x",      exp_r.entry.end_x,   report.end_x);
    check_field("end_y",      exp_r.entry.end_y,   report.end_y);
    check_field("live_count", exp_r.live_count,    report.live_count);
  endfunction

  // Sample every channel at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      foreach (contact_tab[i]) contact_tab[i] = '0;
      live_cnt   = 0;
      mouse_mode = 1'b0;
      report_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) mouse_mode = cfg.mouse_as_touch;
      if (report.valid && report.ready) check_report();
      if (touch.valid && touch.ready)
        track_event(touch.opcode, touch.contact_id, touch.pos_x, touch.pos_y);
    end
    outstanding <= report_q.size();
    fail_count  <= err_cnt;
  end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Touch contact tracker testbench
// Drives directed and random touch, mouse and frame-end events in bursts,
// stalls the report channel on its own pattern, switches mouse emulation
// between phases and takes the verdict from the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import tct_pkg::*;

  // Opcodes the tracker ignores
  localparam logic [3:0] OP_RESERVED_LO = 4'd9;
  localparam logic [3:0] OP_RESERVED_HI = 4'd15;
  localparam int PHASE_ITEMS = 115;
  localparam int IDLE_HOLD   = 40;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SQUARE, RX_SPARSE} rx_style_t;

  logic        clk;
  logic        rst;
  int          fail_count;
  int          outstanding;
  logic [31:0] id_pool [12];
  logic        mode_now;
  int          burst_left;
  int          counted;
  logic [8:0]  rx_tick = '0;
  rx_style_t   rx_style = RX_OPEN;

  tct_event_if  touch_ch ();
  tct_report_if report_ch ();
  tct_cfg_if    cfg_ch ();

  touch_contact_tracker_top uut (
    .clk    (clk),
    .rst    (rst),
    .touch  (touch_ch),
    .report (report_ch),
    .cfg    (cfg_ch)
  );

  tct_checker contact_check (
    .clk         (clk),
    .rst         (rst),
    .touch       (touch_ch),
    .report      (report_ch),
    .cfg         (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the design hangs
  initial begin
    #800000;
    $display("Simulation FAILED");
    $finish;
  end

  // Stall the report channel, switching style each time the 9-bit tick counter wraps
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (rx_tick == '1) rx_style <= rx_style_t'($urandom_range(0, 3));
    case (rx_style)
      RX_OPEN:   report_ch.ready <= 1'b1;
      RX_RANDOM: report_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_SQUARE: report_ch.ready <= rx_tick[3];
      default:   report_ch.ready <= (rx_tick[4:2] == 3'd0);
    endcase
  end

  function automatic logic signed [15:0] rand_pos();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one event; hold valid through a burst, idle between bursts
  task automatic send_event(logic [3:0] op, logic [31:0] id,
                            logic signed [15:0] x, logic signed [15:0] y);
    touch_ch.valid      <= 1'b1;
    touch_ch.opcode     <= op;
    touch_ch.contact_id <= id;
    touch_ch.pos_x      <= x;
    touch_ch.pos_y      <= y;
    do @(posedge clk); while (!touch_ch.ready);
    if (op <= OP_FRAME_END && !(op >= OP_MOUSE_DOWN && op <= OP_MOUSE_EXIT && !mode_now))
      counted++;
    burst_left--;
    if (burst_left <= 0) begin
      touch_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 6);
    end
  endtask

  // Write the emulation bit once every report is in and the block has drained
  task automatic set_mode(logic v);
    touch_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (IDLE_HOLD) @(posedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.mouse_as_touch <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    mode_now = v;
  endtask

  // Mostly contact lifecycle traffic over a small id pool, plus some noise
  task automatic random_item();
    int          pick;
    logic [3:0]  op;
    logic [31:0] id;
    pick = $urandom_range(0, 99);
    id   = id_pool[$urandom_range(0, ($urandom_range(0, 3) == 0) ? 11 : 7)];
    if ($urandom_range(0, 49) == 0) id_pool[$urandom_range(8, 11)] = $urandom;
    if (pick < 25) begin
      op = OP_TOUCH_START;
    end else if (pick < 50) begin
      op = OP_TOUCH_MOVE;
    end else if (pick < 68) begin
      op = OP_TOUCH_END;
    end else if (pick < 78) begin
      op = OP_FRAME_END;
    end else if (pick < 93) begin
      op = 4'($urandom_range(OP_MOUSE_DOWN, OP_MOUSE_EXIT));
    end else if (pick < 96) begin
      op = 4'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
      id = $urandom;
    end else begin
      op = 4'($urandom_range(OP_TOUCH_START, OP_TOUCH_END));
      id = $urandom;
    end
    send_event(op, id, rand_pos(), rand_pos());
  endtask

  initial begin
    int phase;
    int k;
    rst                   <= 1'b1;
    touch_ch.valid        <= 1'b0;
    touch_ch.opcode       <= OP_TOUCH_START;
    touch_ch.contact_id   <= '0;
    touch_ch.pos_x        <= '0;
    touch_ch.pos_y        <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.mouse_as_touch <= 1'b0;
    mode_now   = 1'b0;
    burst_left = 4;
    counted    = 0;
    foreach (id_pool[i]) id_pool[i] = (i < 4) ? 32'(i) : $urandom;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: position extremes, transitions, ignored items, compaction
    send_event(OP_TOUCH_START, 32'h0, 16'sh8000, 16'sh7FFF);
    send_event(OP_TOUCH_MOVE, 32'h0, 16'sh7FFF, 16'sh8000);
    send_event(OP_TOUCH_START, 32'hFFFF_FFFF, 16'sh0, 16'sh0);
    send_event(OP_TOUCH_END, 32'h0, -16'sd1, -16'sd1);
    send_event(OP_TOUCH_END, 32'h0001_2345, 16'sd5, 16'sd6);
    send_event(OP_TOUCH_MOVE, 32'hA5A5_A5A5, 16'sd100, -16'sd100);
    send_event(OP_MOUSE_DOWN, 32'h0, 16'sd7, 16'sd7);
    send_event(OP_RESERVED_HI, 32'h5A5A_5A5A, 16'sd1, 16'sd1);
    send_event(OP_FRAME_END, 32'h0, 16'sd0, 16'sd0);

    // Fill the table and push one contact past the end
    for (k = 0; k < 7; k++) send_event(OP_TOUCH_START, 32'd100 + k, rand_pos(), rand_pos());
    send_event(OP_TOUCH_END, 32'd100, 16'sd9, -16'sd9);
    send_event(OP_FRAME_END, 32'h0, 16'sd0, 16'sd0);

    // Mouse emulation through every mouse event, sharing id 1 with touch
    set_mode(1'b1);
    send_event(OP_MOUSE_ENTER, 32'h0, 16'sd10, 16'sd20);
    send_event(OP_MOUSE_DOWN, 32'h0, 16'sd11, 16'sd21);
    send_event(OP_MOUSE_MOVE, 32'h0, 16'sd12, 16'sd22);
    send_event(OP_MOUSE_DOWN, 32'h0, 16'sd13, 16'sd23);
    send_event(OP_MOUSE_EXIT, 32'h0, 16'sd14, 16'sd24);
    send_event(OP_MOUSE_UP, 32'h0, 16'sd15, 16'sd25);
    send_event(OP_TOUCH_START, MOUSE_ID, 16'sd16, 16'sd26);
    send_event(OP_MOUSE_UP, 32'h0, 16'sd17, 16'sd27);
    send_event(OP_FRAME_END, 32'h0, 16'sd0, 16'sd0);

    // Random phases, alternating mouse emulation
    for (phase = 0; phase < 5; phase++) begin
      set_mode(phase[0]);
      counted = 0;
      while (counted < PHASE_ITEMS) random_item();
    end

    // Drain and give the verdict
    touch_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (IDLE_HOLD) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: touch_contact_tracker_top.f
+incdir+hw/rtl
hw/rtl/tct_pkg.sv
hw/rtl/tct_if.sv
hw/rtl/tct_table.sv
hw/rtl/tct_seq.sv
hw/rtl/touch_contact_tracker_top.sv
hw/rtl/tct_checker.sv
bench/tct_checker.sv
bench/testbench.sv
